// ----- src/dtq_pkg.sv -----
`timescale 1ns / 1ps
package dtq_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int TIME_W    = 48;
	localparam int PER_W     = 32;
	localparam int MAX_OUT   = 16;
	localparam int N_W       = $clog2(MAX_OUT + 1);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 2);

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_RESET   = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;
	localparam logic [2:0] OP_COLLECT = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INACTIVE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NONE_DUE = 2'd3;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DISARM,
		CMD_REFRESH,
		CMD_RESET,
		CMD_TAKE,
		CMD_COLLECT
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t          code;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  base;
		logic [TIME_W-1:0]  now;
		logic [PER_W-1:0]   per;
		logic               rep;
	} cell_cmd_t;

	typedef struct packed {
		logic               found;
		logic [SLOT_W-1:0]  idx;
		logic [TIME_W-1:0]  dl;
	} cand_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// ----- src/deadline_timer_queue_unit.sv -----
`timescale 1ns / 1ps
// Deadline timer queue: sixteen timer slots ordered by deadline, then slot index.
// Input channel s_*: one request per handshake carrying an opcode (add, cancel,
// refresh, reset, query, collect), the current time and operands.
// Output channel m_*: one result per request, or one result per collected slot
// for collect, with m_tlast high on the final result of a request.
// Each slot lives in its own cell; a minimum search walks a candidate down the
// row of cells, one cell per cycle.
// Cancel, refresh, a full add, a refused reset and undefined opcodes show their
// result without a search; add and query run one search, reset passes through
// one more state before its search; collect runs one search per due slot plus
// one (up to 17 searches) and then emits one result a cycle while m_tready allows.
// Requests are taken one at a time: s_tready is high only while the block is idle.
// A result waits in the output register while m_tready is low; the block can
// take the next request meanwhile, but holds its own next result until the
// register drains.
// Reset (arst_n low) frees every slot, zeroes periods, clears the pending wake
// mark and empties the output register.
module deadline_timer_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[2:0], now_ms[50:3], slot_id[54:51], period_ms[86:55],
	// repeat_req[87], from_now[88], zero fill to 96
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], result_slot[5:2], remaining_ms[53:6], any_active[54], wake[55]
	output logic [55:0] m_tdata,
	output logic        m_tlast
);

	localparam int NS = dtq_pkg::NUM_SLOTS;
	localparam int SW = dtq_pkg::SLOT_W;
	localparam int TW = dtq_pkg::TIME_W;
	localparam int PW = dtq_pkg::PER_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RST   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_CEMIT = 3'd4;

	// request fields
	logic [2:0]    op_in;
	logic [TW-1:0] now_in;
	logic [SW-1:0] sid_in;
	logic [PW-1:0] per_in;
	logic          rep_in, fnow_in;

	assign op_in   = s_tdata[2:0];
	assign now_in  = s_tdata[50:3];
	assign sid_in  = s_tdata[54:51];
	assign per_in  = s_tdata[86:55];
	assign rep_in  = s_tdata[87];
	assign fnow_in = s_tdata[88];

	logic [2:0]             state_q;
	logic [2:0]             op_q;
	logic [TW-1:0]          now_q, start_q;
	logic [PW-1:0]          per_q;
	logic [SW-1:0]          tgt_q;
	logic                   due_q, wp_q;
	logic [dtq_pkg::CNT_W-1:0] cnt_q;
	logic [dtq_pkg::N_W-1:0]   n_q, k_q;
	logic [SW-1:0]          list_q [dtq_pkg::MAX_OUT];
	logic [1:0]             pstat_q;
	logic [SW-1:0]          pslot_q;
	logic [TW-1:0]          prem_q;
	logic                   pwake_q;
	dtq_pkg::cell_cmd_t     cmd_q;
	logic                   m_tvalid_q, m_tlast_q;
	logic [55:0]            m_tdata_q;

	// cell row
	dtq_pkg::cand_t         cand [NS+1];
	logic [NS-1:0]          armed_v, taken_v;
	logic [TW-1:0]          dl_v  [NS];
	logic [PW-1:0]          per_v [NS];

	assign cand[0] = '0;

	for (genvar g = 0; g < NS; g++) begin : g_cell
		dtq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (SW'(g)),
			.cmd      (cmd_q),
			.due_mode (due_q),
			.cin      (cand[g]),
			.cout     (cand[g+1]),
			.armed    (armed_v[g]),
			.taken    (taken_v[g]),
			.deadline (dl_v[g]),
			.period   (per_v[g])
		);
	end

	dtq_pkg::cand_t best;
	assign best = cand[NS];

	// lowest free slot
	logic [SW-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int i = NS - 1; i >= 0; i--)
			if (!armed_v[i])
				free_idx = SW'(i);
	end

	// reset start when keeping the original start: deadline minus period, floor zero
	logic [TW-1:0] dsel, psel, keep_start;
	assign dsel       = dl_v[sid_in];
	assign psel       = {{(TW - PW){1'b0}}, per_v[sid_in]};
	assign keep_start = (dsel >= psel) ? dsel - psel : '0;

	logic accept, out_free, emit_ok, scan_done, c_last;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	// hold emission while a command is presented so the cells have applied it
	assign emit_ok   = out_free && (cmd_q.code == dtq_pkg::CMD_NONE);
	assign scan_done = (cnt_q == dtq_pkg::CNT_W'(NS + 1));
	assign c_last    = ((k_q + dtq_pkg::N_W'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			due_q      <= 1'b0;
			wp_q       <= 1'b0;
			cnt_q      <= '0;
			n_q        <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmd_q      <= '0;
			cmd_q.now  <= now_q;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EMIT;
						cnt_q   <= '0;
						due_q   <= 1'b0;
						case (op_in)
							dtq_pkg::OP_ADD: begin
								if (!(&armed_v)) begin
									cmd_q <= '{code: dtq_pkg::CMD_LOAD, slot: free_idx,
										base: now_in, now: now_in, per: per_in, rep: rep_in};
									state_q <= S_SCAN;
								end
							end
							dtq_pkg::OP_CANCEL: begin
								if (armed_v[sid_in]) begin
									cmd_q.code <= dtq_pkg::CMD_DISARM;
									cmd_q.slot <= sid_in;
								end
							end
							dtq_pkg::OP_REFRESH: begin
								if (armed_v[sid_in]) begin
									cmd_q.code <= dtq_pkg::CMD_REFRESH;
									cmd_q.slot <= sid_in;
									cmd_q.base <= now_in;
								end
							end
							dtq_pkg::OP_RESET: begin
								if (!(per_in == per_v[sid_in] && !fnow_in) && armed_v[sid_in])
									state_q <= S_RST;
							end
							dtq_pkg::OP_QUERY: begin
								wp_q    <= 1'b0;
								state_q <= S_SCAN;
							end
							dtq_pkg::OP_COLLECT: begin
								due_q   <= 1'b1;
								n_q     <= '0;
								state_q <= S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_RST: begin
					cmd_q <= '{code: dtq_pkg::CMD_RESET, slot: tgt_q, base: start_q,
						now: now_q, per: per_q, rep: 1'b0};
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + dtq_pkg::CNT_W'(1);
					end else if (op_q == dtq_pkg::OP_COLLECT) begin
						cnt_q <= '0;
						if (best.found && n_q < dtq_pkg::N_W'(dtq_pkg::MAX_OUT)) begin
							n_q        <= n_q + dtq_pkg::N_W'(1);
							cmd_q.code <= dtq_pkg::CMD_TAKE;
							cmd_q.slot <= best.idx;
						end else if (n_q == '0) begin
							due_q   <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							// retire all taken slots at once, then stream the list
							cmd_q.code <= dtq_pkg::CMD_COLLECT;
							cmd_q.base <= now_q;
							k_q        <= '0;
							due_q      <= 1'b0;
							state_q    <= S_CEMIT;
						end
					end else begin
						if ((op_q == dtq_pkg::OP_ADD || op_q == dtq_pkg::OP_RESET) &&
								best.found && best.idx == tgt_q && !wp_q)
							wp_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_CEMIT: begin
					if (emit_ok) begin
						m_tvalid_q <= 1'b1;
						k_q        <= k_q + dtq_pkg::N_W'(1);
						if (c_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_in;
			now_q   <= now_in;
			per_q   <= per_in;
			tgt_q   <= (op_in == dtq_pkg::OP_ADD) ? free_idx : sid_in;
			start_q <= fnow_in ? now_in : keep_start;
			pslot_q <= '0;
			prem_q  <= '0;
			pwake_q <= 1'b0;
			case (op_in) inside
				dtq_pkg::OP_ADD:
					pstat_q <= (&armed_v) ? dtq_pkg::ST_FULL : dtq_pkg::ST_OK;
				dtq_pkg::OP_CANCEL, dtq_pkg::OP_REFRESH:
					pstat_q <= armed_v[sid_in] ? dtq_pkg::ST_OK : dtq_pkg::ST_INACTIVE;
				dtq_pkg::OP_RESET:
					pstat_q <= ((per_in == per_v[sid_in] && !fnow_in) || armed_v[sid_in]) ?
						dtq_pkg::ST_OK : dtq_pkg::ST_INACTIVE;
				dtq_pkg::OP_QUERY, dtq_pkg::OP_COLLECT:
					pstat_q <= dtq_pkg::ST_OK;
				default:
					pstat_q <= dtq_pkg::ST_INACTIVE;
			endcase
		end
		if (state_q == S_SCAN && scan_done) begin
			case (op_q)
				dtq_pkg::OP_ADD: begin
					pslot_q <= tgt_q;
					pwake_q <= best.found && best.idx == tgt_q && !wp_q;
				end
				dtq_pkg::OP_RESET:
					pwake_q <= best.found && best.idx == tgt_q && !wp_q;
				dtq_pkg::OP_QUERY:
					prem_q <= !best.found ? {TW{1'b1}} :
						(now_q >= best.dl) ? '0 : best.dl - now_q;
				dtq_pkg::OP_COLLECT: begin
					if (best.found && n_q < dtq_pkg::N_W'(dtq_pkg::MAX_OUT))
						list_q[n_q[SW-1:0]] <= best.idx;
					else if (n_q == '0)
						pstat_q <= dtq_pkg::ST_NONE_DUE;
				end
				default: ;
			endcase
		end
		if (state_q == S_EMIT && emit_ok) begin
			m_tdata_q <= {pwake_q, |armed_v, prem_q, pslot_q, pstat_q};
			m_tlast_q <= 1'b1;
		end else if (state_q == S_CEMIT && emit_ok) begin
			m_tdata_q <= {1'b0, |armed_v, {TW{1'b0}}, list_q[k_q[SW-1:0]], dtq_pkg::ST_OK};
			m_tlast_q <= c_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= dtq_pkg::N_W'(dtq_pkg::MAX_OUT))
		else $error("collect count beyond limit");

	a_k_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CEMIT |-> k_q < n_q)
		else $error("emit index past collected list");

	a_taken_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == dtq_pkg::OP_COLLECT &&
			cmd_q.code == dtq_pkg::CMD_NONE) |-> $countones(taken_v) == 32'(n_q))
		else $error("taken marks disagree with collected count");

endmodule

// ----- src/dtq_cell.sv -----
`timescale 1ns / 1ps
module dtq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dtq_pkg::SLOT_W-1:0]    idx,
	input  dtq_pkg::cell_cmd_t            cmd,
	input  logic                          due_mode,
	input  dtq_pkg::cand_t                cin,
	output dtq_pkg::cand_t                cout,
	output logic                          armed,
	output logic                          taken,
	output logic [dtq_pkg::TIME_W-1:0]    deadline,
	output logic [dtq_pkg::PER_W-1:0]     period
);

	logic                          armed_q, taken_q, rearm_q;
	logic [dtq_pkg::TIME_W-1:0]    deadline_q;
	logic [dtq_pkg::PER_W-1:0]     period_q;
	dtq_pkg::cand_t                cout_q;
	logic                          hit, own_per, eligible, better;
	logic [dtq_pkg::PER_W-1:0]     addend;
	logic [dtq_pkg::TIME_W-1:0]    sum;

	assign hit     = (cmd.slot == idx);
	assign own_per = (cmd.code == dtq_pkg::CMD_REFRESH) || (cmd.code == dtq_pkg::CMD_COLLECT);
	assign addend  = own_per ? period_q : cmd.per;
	assign sum     = dtq_pkg::sat_add(cmd.base,
		{{(dtq_pkg::TIME_W - dtq_pkg::PER_W){1'b0}}, addend});

	// local candidate: strict less wins, since lower slots sit upstream
	assign eligible = armed_q && (!due_mode || (!taken_q && deadline_q <= cmd.now));
	assign better   = eligible && (!cin.found || deadline_q < cin.dl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			taken_q  <= 1'b0;
			period_q <= '0;
			cout_q   <= '0;
		end else begin
			cout_q <= better ? dtq_pkg::cand_t'{found: 1'b1, idx: idx, dl: deadline_q} : cin;
			case (cmd.code)
				dtq_pkg::CMD_LOAD: begin
					if (hit) begin
						armed_q  <= 1'b1;
						period_q <= cmd.per;
					end
				end
				dtq_pkg::CMD_DISARM: begin
					if (hit)
						armed_q <= 1'b0;
				end
				dtq_pkg::CMD_RESET: begin
					if (hit)
						period_q <= cmd.per;
				end
				dtq_pkg::CMD_TAKE: begin
					if (hit)
						taken_q <= 1'b1;
				end
				dtq_pkg::CMD_COLLECT: begin
					if (taken_q && !rearm_q)
						armed_q <= 1'b0;
					taken_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code) inside
			dtq_pkg::CMD_LOAD: begin
				if (hit) begin
					rearm_q    <= cmd.rep;
					deadline_q <= sum;
				end
			end
			dtq_pkg::CMD_REFRESH, dtq_pkg::CMD_RESET: begin
				if (hit)
					deadline_q <= sum;
			end
			dtq_pkg::CMD_COLLECT: begin
				if (taken_q && rearm_q)
					deadline_q <= sum;
			end
			default: ;
		endcase
	end

	assign cout     = cout_q;
	assign armed    = armed_q;
	assign taken    = taken_q;
	assign deadline = deadline_q;
	assign period   = period_q;

endmodule
